// ----- rtl/fbpc_pkg.sv -----
// Package for the frustum box/point cull block: mode codes, plane entry
// and pipeline sideband types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fbpc_pkg;

  localparam logic [2:0] MODE_LOAD      = 3'd0;
  localparam logic [2:0] MODE_PT_FRUST  = 3'd1;
  localparam logic [2:0] MODE_BOX_FRUST = 3'd2;
  localparam logic [2:0] MODE_PT_HALF   = 3'd3;
  localparam logic [2:0] MODE_BOX_HALF  = 3'd4;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_FRUST = 2'd2,
    KIND_HALF  = 2'd3
  } kind_e;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } plane_t;

  typedef struct packed {
    logic  valid;
    logic  first;
    logic  last;
    kind_e kind;
  } sb_t;

endpackage
`default_nettype wire

// ----- rtl/fbpc_if.sv -----
// Valid/ready channel interfaces for the cull block input and result beats.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface fbpc_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  mode;
  logic        [2:0]  plane_index;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] first_z;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic signed [31:0] second_z;

  modport source (output valid, mode, plane_index, first_x, first_y, first_z,
                  second_x, second_y, second_z, input ready);
  modport sink (input valid, mode, plane_index, first_x, first_y, first_z,
                second_x, second_y, second_z, output ready);
endinterface

interface fbpc_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic was_load;

  modport source (output valid, inside_res, was_load, input ready);
  modport sink (input valid, inside_res, was_load, output ready);
endinterface
`default_nettype wire

// ----- rtl/fbpc_issue.sv -----
// Issue stage: holds one item, walks box corners, saturates corner
// coordinates and owns the plane store. Depends on fbpc_pkg, fbpc_if.
`timescale 1ns / 1ps
`default_nettype none
module fbpc_issue #(
  parameter int FRUSTUM_PLANES = 6,
  parameter int COORD_BITS     = 32
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            adv_i,
  fbpc_in_if.sink                        in_i,
  output fbpc_pkg::sb_t                  sb_o,
  output logic signed [COORD_BITS-1:0]   cx_o,
  output logic signed [COORD_BITS-1:0]   cy_o,
  output logic signed [COORD_BITS-1:0]   cz_o,
  output fbpc_pkg::plane_t               planes_o [FRUSTUM_PLANES+1]
);
  import fbpc_pkg::*;

  localparam int ENTRIES = FRUSTUM_PLANES + 1;
  localparam int EW      = ((COORD_BITS > 33) ? COORD_BITS : 33) + 1;
  localparam logic signed [EW-1:0] LIM_HI = (EW'(1) <<< (COORD_BITS - 1)) - EW'(1);
  localparam logic signed [EW-1:0] LIM_LO = -LIM_HI - EW'(1);

  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [32:0] v);
    logic signed [EW-1:0] ve;
    ve = EW'(v);
    if (ve > LIM_HI) return COORD_BITS'(LIM_HI);
    if (ve < LIM_LO) return COORD_BITS'(LIM_LO);
    return COORD_BITS'(ve);
  endfunction

  logic               busy_q;
  logic [2:0]         mode_q, idx_q, corner_q;
  logic signed [31:0] ox_q, oy_q, oz_q, wx_q, wy_q, wz_q;
  logic               is_box, last, issue, take;
  kind_e              kind;
  plane_t             store_q [ENTRIES];

  always_comb begin
    is_box = (mode_q == MODE_BOX_FRUST) || (mode_q == MODE_BOX_HALF);
    last   = !is_box || (corner_q == 3'd7);
    unique case (mode_q)
      MODE_LOAD:                     kind = KIND_LOAD;
      MODE_PT_FRUST, MODE_BOX_FRUST: kind = KIND_FRUST;
      MODE_PT_HALF, MODE_BOX_HALF:   kind = KIND_HALF;
      default:                       kind = KIND_NONE;
    endcase
  end

  assign issue      = busy_q && adv_i;
  assign in_i.ready = !busy_q || (issue && last);
  assign take       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      corner_q <= 3'd0;
    end else if (take) begin
      busy_q   <= 1'b1;
      corner_q <= 3'd0;
    end else if (issue) begin
      busy_q   <= !last;
      corner_q <= corner_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      mode_q <= in_i.mode;
      idx_q  <= in_i.plane_index;
      ox_q   <= in_i.first_x;
      oy_q   <= in_i.first_y;
      oz_q   <= in_i.first_z;
      wx_q   <= in_i.second_x;
      wy_q   <= in_i.second_y;
      wz_q   <= in_i.second_z;
    end
  end

  // Store is written as the load issues; tests read it one stage later.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < ENTRIES; e++) store_q[e] <= '0;
    end else if (issue && (kind == KIND_LOAD)) begin
      for (int e = 0; e < ENTRIES; e++) begin
        if ({1'b0, idx_q} == 4'(e)) begin
          store_q[e] <= '{nx: ox_q, ny: oy_q, nz: oz_q, px: wx_q, py: wy_q, pz: wz_q};
        end
      end
    end
  end

  assign planes_o = store_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_o <= '{valid: 1'b0, first: 1'b0, last: 1'b0, kind: KIND_NONE};
    end else if (adv_i) begin
      sb_o <= '{valid: busy_q, first: (corner_q == 3'd0), last: last, kind: kind};
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      cx_o <= sat((is_box && corner_q[0]) ? 33'(ox_q) + 33'(wx_q) : 33'(ox_q));
      cy_o <= sat((is_box && corner_q[1]) ? 33'(oy_q) + 33'(wy_q) : 33'(oy_q));
      cz_o <= sat((is_box && corner_q[2]) ? 33'(oz_q) + 33'(wz_q) : 33'(oz_q));
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fbpc_plane_dot.sv -----
// Four-stage exact sign test of dot(n, c - q) for one plane entry.
// Depends on fbpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fbpc_plane_dot #(
  parameter int COORD_BITS = 32
) (
  input  wire                           clk_i,
  input  wire                           adv_i,
  input  wire signed [COORD_BITS-1:0]   cx_i,
  input  wire signed [COORD_BITS-1:0]   cy_i,
  input  wire signed [COORD_BITS-1:0]   cz_i,
  input  fbpc_pkg::plane_t              plane_i,
  output logic                          pass_o
);
  import fbpc_pkg::*;

  localparam int DW = ((COORD_BITS > 32) ? COORD_BITS : 32) + 1;
  localparam int QW = DW - 24;
  localparam int HW = 32 + QW;
  localparam int LW = 57;
  localparam int TW = HW + 2 + 24 + 1;

  logic signed [DW-1:0] d_q [3];
  logic signed [31:0]   n_q [3];
  logic signed [HW-1:0] hi_q [3];
  logic signed [LW-1:0] lo_q [3];
  logic signed [HW+1:0] sh_q;
  logic signed [LW+1:0] sl_q;
  logic signed [TW-1:0] total;

  // stage 2: difference to plane point, latch the normal
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d_q[0] <= DW'(cx_i) - DW'(plane_i.px);
      d_q[1] <= DW'(cy_i) - DW'(plane_i.py);
      d_q[2] <= DW'(cz_i) - DW'(plane_i.pz);
      n_q[0] <= plane_i.nx;
      n_q[1] <= plane_i.ny;
      n_q[2] <= plane_i.nz;
    end
  end

  // stage 3: split d into high signed limb and low 24-bit limb, multiply each by n
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < 3; k++) begin
        hi_q[k] <= HW'(n_q[k]) * HW'($signed(d_q[k][DW-1:24]));
        lo_q[k] <= LW'(n_q[k]) * LW'($signed({1'b0, d_q[k][23:0]}));
      end
    end
  end

  // stage 4: limb sums
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sh_q <= (HW+2)'(hi_q[0]) + (HW+2)'(hi_q[1]) + (HW+2)'(hi_q[2]);
      sl_q <= (LW+2)'(lo_q[0]) + (LW+2)'(lo_q[1]) + (LW+2)'(lo_q[2]);
    end
  end

  // stage 5: recombine, sign of the exact dot
  assign total = (TW'(sh_q) <<< 24) + TW'(sl_q);

  always_ff @(posedge clk_i) begin
    if (adv_i) pass_o <= !total[TW-1];
  end

endmodule
`default_nettype wire

// ----- rtl/frustum_box_point_cull.sv -----
// Top level of the frustum box/point cull block: issue stage, one dot unit
// per plane entry, corner reduction. Depends on all the other rtl files.
`timescale 1ns / 1ps
`default_nettype none
//
// channel  dir  beat contents
// in_i     in   mode, plane_index, first_x/y/z, second_x/y/z (Q16.16)
// out_o    out  inside_res, was_load
//
// Loads, point tests and unused modes issue as one item; a box issues its
// 8 corners, one corner per cycle unless the output stalls, all plane
// entries tested in parallel by the dot units. A box result follows its
// last corner.
// Reset clears the plane store to zero (a zero entry passes every point).
// Output backpressure freezes the whole pipeline; nothing is dropped or redone.
//
module frustum_box_point_cull #(
  parameter int FRUSTUM_PLANES = 6,
  parameter int COORD_BITS     = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  fbpc_in_if.sink     in_i,
  fbpc_out_if.source  out_o
);
  import fbpc_pkg::*;

  localparam int ENTRIES = FRUSTUM_PLANES + 1;
  localparam int DEPTH   = 4;   // dot unit stages

  logic                         adv;
  sb_t                          sb1;
  sb_t                          sb_q [DEPTH];
  logic signed [COORD_BITS-1:0] cx, cy, cz;
  plane_t                       planes [ENTRIES];
  logic [ENTRIES-1:0]           pass;
  logic                         out_valid_q, inside_q, load_q, acc_q;
  logic                         corner_in, res;

  // whole pipeline moves when the result register is free
  assign adv = !out_valid_q || out_o.ready;

  fbpc_issue #(
    .FRUSTUM_PLANES(FRUSTUM_PLANES),
    .COORD_BITS    (COORD_BITS)
  ) u_issue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .in_i    (in_i),
    .sb_o    (sb1),
    .cx_o    (cx),
    .cy_o    (cy),
    .cz_o    (cz),
    .planes_o(planes)
  );

  for (genvar e = 0; e < ENTRIES; e++) begin : g_dot
    fbpc_plane_dot #(.COORD_BITS(COORD_BITS)) u_dot (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .cx_i   (cx),
      .cy_i   (cy),
      .cz_i   (cz),
      .plane_i(planes[e]),
      .pass_o (pass[e])
    );
  end

  // sideband rides alongside the dot unit stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DEPTH; s++) begin
        sb_q[s] <= '{valid: 1'b0, first: 1'b0, last: 1'b0, kind: KIND_NONE};
      end
    end else if (adv) begin
      sb_q[0] <= sb1;
      for (int s = 1; s < DEPTH; s++) sb_q[s] <= sb_q[s-1];
    end
  end

  // per-corner verdict, then OR over the corners of one item
  always_comb begin
    case (sb_q[DEPTH-1].kind)
      KIND_FRUST: corner_in = &pass[FRUSTUM_PLANES-1:0];
      KIND_HALF:  corner_in = pass[FRUSTUM_PLANES];
      default:    corner_in = 1'b0;
    endcase
    res = sb_q[DEPTH-1].first ? corner_in : (acc_q | corner_in);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sb_q[DEPTH-1].valid && sb_q[DEPTH-1].last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && sb_q[DEPTH-1].valid) begin
      acc_q    <= res;
      inside_q <= res;
      load_q   <= (sb_q[DEPTH-1].kind == KIND_LOAD);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.inside_res = inside_q;
  assign out_o.was_load   = load_q;

`ifndef SYNTHESIS
  // a load acknowledge never reports inside
  a_load_not_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.was_load |-> !out_o.inside_res)
    else $error("load beat reports inside");

  // a box holds the issue stage for its further corners
  a_box_holds_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready &&
    (in_i.mode == MODE_BOX_FRUST || in_i.mode == MODE_BOX_HALF) |=> !in_i.ready)
    else $error("input taken during box corner walk");

  // a stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.inside_res))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

// ----- test/frustum_box_point_cull_test.sv -----
// Self-checking testbench for frustum_box_point_cull: plane loads, point and box
// culling tests, random traffic with stalls, checked against an in-bench predictor.
// Depends on fbpc_pkg, fbpc_if and the frustum_box_point_cull RTL.
`timescale 1ns / 1ps
module frustum_box_point_cull_test;
  import fbpc_pkg::*;

  localparam int PLANES = 6;
  localparam int ENTRIES = PLANES + 1;
  localparam logic [2:0] MODE_UNUSED = 3'd5;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_BEATS = 1850;

  // one stimulus row; exp_valid marks rows whose result is typed in
  typedef struct {
    logic [2:0]         mode;
    logic [2:0]         idx;
    logic signed [31:0] fx, fy, fz, sx, sy, sz;
    bit                 exp_valid;
    bit                 exp_inside;
    bit                 exp_load;
  } beat_t;

  typedef struct {
    bit hit;
    bit load;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fbpc_in_if  in_ch ();
  fbpc_out_if out_ch ();

  frustum_box_point_cull i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor copy of the plane store
  logic signed [31:0] pl_nx [ENTRIES];
  logic signed [31:0] pl_ny [ENTRIES];
  logic signed [31:0] pl_nz [ENTRIES];
  logic signed [31:0] pl_px [ENTRIES];
  logic signed [31:0] pl_py [ENTRIES];
  logic signed [31:0] pl_pz [ENTRIES];

  verdict_t verdict_q [$];
  int       fail_count = 0;
  int       idle_cycles = 0;
  bit       stim_done = 1'b0;
  bit       hold_long = 1'b0;

  // clamp a 33-bit corner sum back to the signed 32-bit range
  function automatic logic signed [31:0] clamp_coord(logic signed [32:0] v);
    if (v > 33'sd2147483647) return 32'sh7fffffff;
    if (v < -33'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // exact sign of dot(n, c - q): 33-bit diffs, 65-bit products, 68-bit sum
  function automatic bit plane_passes(int e, logic signed [31:0] cx,
                                      logic signed [31:0] cy, logic signed [31:0] cz);
    logic signed [67:0] acc;
    acc = 68'(pl_nx[e] * (33'(cx) - 33'(pl_px[e])))
        + 68'(pl_ny[e] * (33'(cy) - 33'(pl_py[e])))
        + 68'(pl_nz[e] * (33'(cz) - 33'(pl_pz[e])));
    return acc >= 0;
  endfunction

  function automatic bit corner_inside(bit half, logic signed [31:0] cx,
                                       logic signed [31:0] cy, logic signed [31:0] cz);
    if (half) return plane_passes(PLANES, cx, cy, cz);
    for (int e = 0; e < PLANES; e++)
      if (!plane_passes(e, cx, cy, cz)) return 1'b0;
    return 1'b1;
  endfunction

  // predicts the verdict of one beat and applies loads to the store
  function automatic verdict_t cull_predict(beat_t b);
    verdict_t v;
    logic signed [31:0] cx, cy, cz;
    v = '{hit: 1'b0, load: 1'b0};
    case (b.mode)
      MODE_LOAD: begin
        if (b.idx < ENTRIES) begin
          pl_nx[b.idx] = b.fx; pl_ny[b.idx] = b.fy; pl_nz[b.idx] = b.fz;
          pl_px[b.idx] = b.sx; pl_py[b.idx] = b.sy; pl_pz[b.idx] = b.sz;
        end
        v.load = 1'b1;
      end
      MODE_PT_FRUST, MODE_PT_HALF: begin
        v.hit = corner_inside(b.mode == MODE_PT_HALF, b.fx, b.fy, b.fz);
      end
      MODE_BOX_FRUST, MODE_BOX_HALF: begin
        for (int c = 0; c < 8; c++) begin
          cx = c[0] ? clamp_coord(33'(b.fx) + 33'(b.sx)) : b.fx;
          cy = c[1] ? clamp_coord(33'(b.fy) + 33'(b.sy)) : b.fy;
          cz = c[2] ? clamp_coord(33'(b.fz) + 33'(b.sz)) : b.fz;
          if (corner_inside(b.mode == MODE_BOX_HALF, cx, cy, cz)) v.hit = 1'b1;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom);
      default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    endcase
  endfunction

  function automatic beat_t make_beat(logic [2:0] m, logic [2:0] i,
      logic signed [31:0] fx, logic signed [31:0] fy, logic signed [31:0] fz,
      logic signed [31:0] sx, logic signed [31:0] sy, logic signed [31:0] sz,
      bit ev, bit ei, bit el);
    beat_t b;
    b.mode = m; b.idx = i;
    b.fx = fx; b.fy = fy; b.fz = fz; b.sx = sx; b.sy = sy; b.sz = sz;
    b.exp_valid = ev; b.exp_inside = ei; b.exp_load = el;
    return b;
  endfunction

  // drive one beat from a falling edge and wait for its acceptance;
  // valid drops only when an idle gap comes before the beat
  task automatic send_beat(beat_t b);
    verdict_t v;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= b.mode;
    in_ch.plane_index <= b.idx;
    in_ch.first_x <= b.fx; in_ch.first_y <= b.fy; in_ch.first_z <= b.fz;
    in_ch.second_x <= b.sx; in_ch.second_y <= b.sy; in_ch.second_z <= b.sz;
    do @(posedge clk_i); while (!in_ch.ready);
    v = cull_predict(b);
    if (b.exp_valid && (v.hit != b.exp_inside || v.load != b.exp_load)) begin
      $display("%0t: table row mode %0d expected %0b/%0b predicted %0b/%0b", $time,
               b.mode, b.exp_inside, b.exp_load, v.hit, v.load);
      fail_count++;
    end
    if (b.exp_valid) v = '{hit: b.exp_inside, load: b.exp_load};
    verdict_q.insert(verdict_q.size(), v);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
  endtask

  beat_t directed [$];

  task automatic add_row(beat_t b);
    directed.insert(directed.size(), b);
  endtask

  initial begin
    beat_t b;
    logic [2:0] m;
    in_ch.valid = 1'b0; in_ch.mode = MODE_LOAD; in_ch.plane_index = '0;
    in_ch.first_x = '0; in_ch.first_y = '0; in_ch.first_z = '0;
    in_ch.second_x = '0; in_ch.second_y = '0; in_ch.second_z = '0;
    for (int e = 0; e < ENTRIES; e++) begin
      pl_nx[e] = '0; pl_ny[e] = '0; pl_nz[e] = '0;
      pl_px[e] = '0; pl_py[e] = '0; pl_pz[e] = '0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // after reset every zero plane passes anything
    add_row(make_beat(MODE_PT_FRUST, 0, 32'sh80000000, 32'sh7fffffff, 0,
                      0, 0, 0, 1, 1, 0));
    add_row(make_beat(MODE_PT_HALF, 7, 32'sh7fffffff, 32'sh80000000,
                      32'sh7fffffff, -1, -1, -1, 1, 1, 0));
    add_row(make_beat(MODE_BOX_FRUST, 0, 32'sh7fffffff, 32'sh7fffffff,
                      32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                      32'sh7fffffff, 1, 1, 0));
    // unused modes: no change, all zero
    add_row(make_beat(MODE_UNUSED, 0, -1, -1, -1, -1, -1, -1, 1, 0, 0));
    add_row(make_beat(3'd6, 6, 1, 1, 1, 1, 1, 1, 1, 0, 0));
    add_row(make_beat(3'd7, 7, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    // load at index out of range is acknowledged, writes nothing
    add_row(make_beat(MODE_LOAD, 7, -1, -1, -1, 5, 5, 5, 1, 0, 1));
    // half-space: front +x at origin
    add_row(make_beat(MODE_LOAD, 6, 32'sh00010000, 0, 0, 0, 0, 0, 1, 0, 1));
    add_row(make_beat(MODE_PT_HALF, 0, -1, 0, 0, 0, 0, 0, 1, 0, 0));
    add_row(make_beat(MODE_PT_HALF, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0));
    add_row(make_beat(MODE_BOX_HALF, 0, -5, 0, 0, 4, 0, 0, 1, 0, 0));
    add_row(make_beat(MODE_BOX_HALF, 0, -5, 0, 0, 5, 0, 0, 1, 1, 0));
    // saturation: origin at min plus negative extent stays at min
    add_row(make_beat(MODE_BOX_HALF, 0, 32'sh80000000, 0, 0, 32'sh80000000,
                      0, 0, 1, 0, 0));
    // frustum: planes of the box from 0.0 to 16.0 on each axis, extreme x normals
    for (int e = 0; e < PLANES; e++)
      add_row(make_beat(MODE_LOAD, e[2:0],
          e == 0 ? 32'sh7fffffff : (e == 1 ? 32'sh80000000 : 0),
          e == 2 ? 32'sh00010000 : (e == 3 ? -32'sh00010000 : 0),
          e == 4 ? 32'sh00010000 : (e == 5 ? -32'sh00010000 : 0),
          e == 1 ? 32'sh00100000 : 0, e == 3 ? 32'sh00100000 : 0,
          e == 5 ? 32'sh00100000 : 0, 1, 0, 1));
    add_row(make_beat(MODE_PT_FRUST, 0, 32'sh00080000, 32'sh00080000,
                      32'sh00080000, 0, 0, 0, 0, 0, 0));
    add_row(make_beat(MODE_PT_FRUST, 0, -1, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_beat(MODE_BOX_FRUST, 0, -32'sh00200000, -32'sh00200000,
                      -32'sh00200000, 32'sh00280000, 32'sh00280000,
                      32'sh00280000, 0, 0, 0));
    add_row(make_beat(MODE_BOX_FRUST, 0, 32'sh00200000, 0, 0,
                      32'sh7fffffff, 0, 0, 0, 0, 0));
    foreach (directed[i]) send_beat(directed[i]);
    wait_drained();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      // long receiver hold-off, and a full drain pause
      if (n == 400) hold_long = 1'b1;
      if (n == 900) wait_drained();
      case ($urandom_range(0, 9))
        0, 1: m = MODE_LOAD;
        2: m = MODE_PT_FRUST;
        3, 4: m = MODE_BOX_FRUST;
        5: m = MODE_PT_HALF;
        6, 7: m = MODE_BOX_HALF;
        8: m = $urandom_range(5, 7);
        default: m = $urandom_range(0, 7);
      endcase
      b = make_beat(m, $urandom_range(0, 9) == 0 ? 3'd7 : $urandom_range(0, 6),
                    rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), 0, 0, 0);
      send_beat(b);
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    stim_done = 1'b1;
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_long = 1'b0;
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      @(negedge clk_i);
      out_ch.ready <= 1'b0;
      repeat ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16)) @(negedge clk_i);
    end
  end

  // result checker and watchdog at the rising edge
  always @(posedge clk_i) begin
    verdict_t v;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result beat inside=%0b load=%0b", $time,
                   out_ch.inside_res, out_ch.was_load);
          fail_count++;
        end else begin
          v = verdict_q.pop_front();
          if (out_ch.inside_res !== v.hit) begin
            $display("%0t: inside_res expected %0b actual %0b", $time, v.hit,
                     out_ch.inside_res);
            fail_count++;
          end
          if (out_ch.was_load !== v.load) begin
            $display("%0t: was_load expected %0b actual %0b", $time, v.load,
                     out_ch.was_load);
            fail_count++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT && !stim_done) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end
endmodule
